>>> design/bplru_pkg.sv
// Shared types, constants and codes for the buffer pool pin/LRU manager.
package bplru_pkg;

   localparam int Frames    = 16;
   localparam int PinBits   = 8;
   localparam int FrameBits = $clog2(Frames);
   localparam int CntBits   = $clog2(Frames + 1);

   localparam logic [2:0] REQ_FETCH     = 3'd0;
   localparam logic [2:0] REQ_NEW       = 3'd1;
   localparam logic [2:0] REQ_UNPIN     = 3'd2;
   localparam logic [2:0] REQ_FLUSH     = 3'd3;
   localparam logic [2:0] REQ_FLUSH_ALL = 3'd4;

   localparam logic [2:0] KIND_WRITEBACK = 3'd0;
   localparam logic [2:0] KIND_LOAD      = 3'd1;
   localparam logic [2:0] KIND_GRANTED   = 3'd2;
   localparam logic [2:0] KIND_FAILED    = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;
   localparam logic [2:0] KIND_ZERO      = 3'd5;

   // datapath operations issued by the controller
   localparam logic [3:0] OP_NONE       = 4'd0;
   localparam logic [3:0] OP_CAPTURE    = 4'd1;
   localparam logic [3:0] OP_LOOKUP     = 4'd2;
   localparam logic [3:0] OP_HIT        = 4'd3;
   localparam logic [3:0] OP_SCAN_INIT  = 4'd4;
   localparam logic [3:0] OP_SCAN_STEP  = 4'd5;
   localparam logic [3:0] OP_TAKE_FREE  = 4'd6;
   localparam logic [3:0] OP_EVICT      = 4'd7;
   localparam logic [3:0] OP_INSTALL    = 4'd8;
   localparam logic [3:0] OP_UNPIN      = 4'd9;
   localparam logic [3:0] OP_FLUSH      = 4'd10;
   localparam logic [3:0] OP_FALL_INIT  = 4'd11;
   localparam logic [3:0] OP_FALL_STEP  = 4'd12;
   localparam logic [3:0] OP_TOUCH_STEP = 4'd13;
   localparam logic [3:0] OP_TOUCH_INIT = 4'd14;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] page_id;
      logic        dirty_flag;
   } req_type_type;

   typedef struct packed {
      logic [2:0]           kind;
      logic [FrameBits-1:0] frame;
      logic [31:0]          page;
      logic                 was_hit;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] emit_kind;
      logic       emit;
      logic       emit_hit;
      logic       emit_last;
      logic       emit_zero;
      logic       emit_frame0;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req;
      logic       hit;
      logic       free_avail;
      logic       scan_found;
      logic       scan_end;
      logic       victim_dirty;
      logic       fall_dirty;
      logic       fall_end;
      logic       touch_end;
   } sts_type;

endpackage

>>> design/bplru_ctrl.sv
// Request sequencer for the buffer pool manager.
module bplru_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bplru_pkg::sts_type sts,
   output bplru_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOOK   = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_VICT   = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_EVICT  = 4'd5;
   localparam logic [3:0] S_INST   = 4'd6;
   localparam logic [3:0] S_TOUCH  = 4'd7;
   localparam logic [3:0] S_GRANT  = 4'd8;
   localparam logic [3:0] S_FLUSH  = 4'd9;
   localparam logic [3:0] S_FALL   = 4'd10;
   localparam logic [3:0] S_HTOUCH = 4'd11;
   localparam logic [3:0] S_HGRANT = 4'd12;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.op   = bplru_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = bplru_pkg::OP_CAPTURE;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.op   = bplru_pkg::OP_LOOKUP;
            state_in = S_DISP;
         end
         S_DISP: begin
            unique case (sts.req) inside
               bplru_pkg::REQ_FETCH: begin
                  if (sts.hit) begin
                     cmd.op   = bplru_pkg::OP_TOUCH_INIT;
                     state_in = S_HTOUCH;
                  end else begin
                     state_in = S_VICT;
                  end
               end
               bplru_pkg::REQ_NEW: state_in = S_VICT;
               bplru_pkg::REQ_UNPIN, bplru_pkg::REQ_FLUSH: begin
                  if (!sts.hit) begin
                     cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_FAILED;
                     cmd.emit_last = 1'b1; cmd.emit_frame0 = 1'b1;
                     state_in = S_IDLE;
                  end else if (sts.req == bplru_pkg::REQ_UNPIN) begin
                     cmd.op = bplru_pkg::OP_UNPIN;
                     cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_DONE;
                     cmd.emit_last = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_WRITEBACK;
                     state_in = S_FLUSH;
                  end
               end
               bplru_pkg::REQ_FLUSH_ALL: begin
                  cmd.op   = bplru_pkg::OP_FALL_INIT;
                  state_in = S_FALL;
               end
               default: begin
                  cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_FAILED;
                  cmd.emit_last = 1'b1; cmd.emit_frame0 = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_HTOUCH: begin
            cmd.op = bplru_pkg::OP_TOUCH_STEP;
            if (sts.touch_end) state_in = S_HGRANT;
         end
         S_HGRANT: begin
            cmd.op = bplru_pkg::OP_HIT;
            cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_GRANTED;
            cmd.emit_hit = 1'b1; cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         S_VICT: begin
            if (sts.free_avail) begin
               cmd.op   = bplru_pkg::OP_TAKE_FREE;
               state_in = S_INST;
            end else begin
               cmd.op   = bplru_pkg::OP_SCAN_INIT;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_found) begin
               state_in = S_EVICT;
            end else if (sts.scan_end) begin
               cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_FAILED;
               cmd.emit_last = 1'b1; cmd.emit_frame0 = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.op = bplru_pkg::OP_SCAN_STEP;
            end
         end
         S_EVICT: begin
            cmd.op = bplru_pkg::OP_EVICT;
            if (sts.victim_dirty) begin
               cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_WRITEBACK;
            end
            state_in = S_INST;
         end
         S_INST: begin
            cmd.op   = bplru_pkg::OP_INSTALL;
            cmd.emit = 1'b1;
            cmd.emit_kind = (sts.req == bplru_pkg::REQ_NEW) ? bplru_pkg::KIND_ZERO
                                                             : bplru_pkg::KIND_LOAD;
            state_in = S_TOUCH;
         end
         S_TOUCH: begin
            cmd.op = bplru_pkg::OP_TOUCH_STEP;
            if (sts.touch_end) state_in = S_GRANT;
         end
         S_GRANT: begin
            cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_GRANTED;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         S_FLUSH: begin
            cmd.op   = bplru_pkg::OP_FLUSH;
            cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_DONE;
            cmd.emit_last = 1'b1;
            state_in = S_IDLE;
         end
         S_FALL: begin
            cmd.op = bplru_pkg::OP_FALL_STEP;
            if (sts.fall_dirty) begin
               cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_WRITEBACK;
            end else if (sts.fall_end) begin
               cmd.emit = 1'b1; cmd.emit_kind = bplru_pkg::KIND_DONE;
               cmd.emit_last = 1'b1; cmd.emit_zero = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> design/bplru_dp.sv
// Frame table, recency list and result register of the buffer pool manager.
module bplru_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  bplru_pkg::req_type_type req,
   input  bplru_pkg::cmd_type      cmd,
   output bplru_pkg::sts_type      sts,
   output logic                    rsp_valid,
   output bplru_pkg::rsp_type      rsp
);

   localparam int FB = bplru_pkg::FrameBits;
   localparam int CB = bplru_pkg::CntBits;
   localparam logic [bplru_pkg::PinBits-1:0] PinMax = '1;
   localparam logic [bplru_pkg::PinBits-1:0] PinOne = {{(bplru_pkg::PinBits-1){1'b0}}, 1'b1};

   // frame state
   logic [31:0]                     tag_ff   [bplru_pkg::Frames];
   logic [bplru_pkg::Frames-1:0]    valid_ff;
   logic [bplru_pkg::Frames-1:0]    dirty_ff;
   logic [bplru_pkg::PinBits-1:0]   pins_ff  [bplru_pkg::Frames];
   logic [FB-1:0]                   order_ff [bplru_pkg::Frames];
   logic [CB-1:0]                   len_ff;
   logic [CB-1:0]                   free_ff;

   // transaction and working registers
   bplru_pkg::req_type_type req_ff;
   logic [FB-1:0]           sel_ff;     // frame in use
   logic                    hit_ff;
   logic [CB-1:0]           idx_ff;     // scan / sweep position
   logic [CB-1:0]           tpos_ff;    // touch shift position
   logic                    tfound_ff;  // frame already located in list
   logic                    rsp_valid_ff;
   bplru_pkg::rsp_type      rsp_ff;

   // combinational lookup: lowest matching valid frame
   logic          lk_hit;
   logic [FB-1:0] lk_frame;
   always_comb begin
      lk_hit   = 1'b0;
      lk_frame = '0;
      for (int i = bplru_pkg::Frames - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == req_ff.page_id) begin
            lk_hit   = 1'b1;
            lk_frame = FB'(i);
         end
      end
   end

   // list position of the selected frame, searched from the front
   logic [CB-1:0] hit_pos;
   always_comb begin
      hit_pos = '0;
      for (int i = bplru_pkg::Frames - 1; i >= 0; i--) begin
         if (CB'(i) < len_ff && order_ff[i] == sel_ff) hit_pos = CB'(i);
      end
   end

   // scan candidate: list entry idx_ff-1
   logic [FB-1:0] sc_frame;
   logic [FB-1:0] sc_pos;
   assign sc_pos   = FB'(idx_ff - 1'b1);
   assign sc_frame = order_ff[sc_pos];

   // touch: list position tpos_ff
   logic [FB-1:0] t_pos;
   assign t_pos = tpos_ff[FB-1:0];

   assign sts.req          = req_ff.req_type;
   assign sts.hit          = hit_ff;
   assign sts.free_avail   = (free_ff != '0);
   assign sts.scan_end     = (idx_ff == '0);
   assign sts.scan_found   = (idx_ff != '0) && (pins_ff[sc_frame] == '0);
   assign sts.victim_dirty = dirty_ff[sc_frame];
   assign sts.fall_end     = idx_ff[CB-1];
   assign sts.fall_dirty   = !idx_ff[CB-1] && valid_ff[idx_ff[FB-1:0]]
                             && dirty_ff[idx_ff[FB-1:0]];
   assign sts.touch_end    = (tpos_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         len_ff       <= '0;
         free_ff      <= CB'(bplru_pkg::Frames);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < bplru_pkg::Frames; i++) begin
            tag_ff[i]  <= '0;
            pins_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= cmd.emit;
         unique case (cmd.op)
            bplru_pkg::OP_CAPTURE: req_ff <= req;
            bplru_pkg::OP_LOOKUP: begin
               hit_ff <= lk_hit;
               sel_ff <= lk_frame;
            end
            bplru_pkg::OP_HIT: begin
               if (pins_ff[sel_ff] != PinMax) pins_ff[sel_ff] <= pins_ff[sel_ff] + 1'b1;
            end
            bplru_pkg::OP_TAKE_FREE: begin
               free_ff <= free_ff - 1'b1;
               sel_ff  <= FB'(free_ff - 1'b1);
               tpos_ff <= len_ff;
               tfound_ff <= 1'b0;
            end
            bplru_pkg::OP_SCAN_INIT: idx_ff <= len_ff;
            bplru_pkg::OP_SCAN_STEP: idx_ff <= idx_ff - 1'b1;
            bplru_pkg::OP_EVICT: begin
               // the victim stays in the list; the touch pass moves it to front
               sel_ff    <= sc_frame;
               valid_ff[sc_frame] <= 1'b0;
               dirty_ff[sc_frame] <= 1'b0;
               tpos_ff   <= CB'(sc_pos);
               tfound_ff <= 1'b1;
            end
            bplru_pkg::OP_INSTALL: begin
               for (int i = 0; i < bplru_pkg::Frames; i++) begin
                  if (req_ff.req_type == bplru_pkg::REQ_NEW && FB'(i) != sel_ff
                      && valid_ff[i] && tag_ff[i] == req_ff.page_id) begin
                     valid_ff[i] <= 1'b0;
                     dirty_ff[i] <= 1'b0;
                  end
               end
               tag_ff[sel_ff]   <= req_ff.page_id;
               valid_ff[sel_ff] <= 1'b1;
               dirty_ff[sel_ff] <= (req_ff.req_type == bplru_pkg::REQ_NEW);
               pins_ff[sel_ff]  <= PinOne;
               if (!tfound_ff) begin
                  if (len_ff != CB'(bplru_pkg::Frames)) len_ff <= len_ff + 1'b1;
               end
            end
            bplru_pkg::OP_TOUCH_INIT: begin
               // hit: start the shift at the frame's list position
               tpos_ff   <= hit_pos;
               tfound_ff <= 1'b0;
            end
            bplru_pkg::OP_TOUCH_STEP: begin
               if (tpos_ff == '0) begin
                  order_ff[0] <= sel_ff;
               end else begin
                  if (t_pos != '0 || tpos_ff == '0)
                     order_ff[t_pos] <= order_ff[FB'(tpos_ff - 1'b1)];
                  tpos_ff <= tpos_ff - 1'b1;
               end
            end
            bplru_pkg::OP_UNPIN: begin
               if (req_ff.dirty_flag) dirty_ff[sel_ff] <= 1'b1;
               if (pins_ff[sel_ff] != '0) pins_ff[sel_ff] <= pins_ff[sel_ff] - 1'b1;
            end
            bplru_pkg::OP_FLUSH: dirty_ff[sel_ff] <= 1'b0;
            bplru_pkg::OP_FALL_INIT: idx_ff <= '0;
            bplru_pkg::OP_FALL_STEP: begin
               if (!idx_ff[CB-1]) begin
                  dirty_ff[idx_ff[FB-1:0]] <= 1'b0;
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.kind    <= cmd.emit_kind;
         rsp_ff.was_hit <= cmd.emit_hit;
         rsp_ff.last    <= cmd.emit_last;
         if (cmd.emit_zero) begin
            rsp_ff.frame <= '0;
            rsp_ff.page  <= '0;
         end else if (cmd.emit_frame0) begin
            rsp_ff.frame <= '0;
            rsp_ff.page  <= req_ff.page_id;
         end else if (cmd.op == bplru_pkg::OP_FALL_STEP) begin
            rsp_ff.frame <= idx_ff[FB-1:0];
            rsp_ff.page  <= tag_ff[idx_ff[FB-1:0]];
         end else if (cmd.op == bplru_pkg::OP_EVICT) begin
            rsp_ff.frame <= sc_frame;
            rsp_ff.page  <= tag_ff[sc_frame];
         end else begin
            rsp_ff.frame <= sel_ff;
            rsp_ff.page  <= req_ff.page_id;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> design/buffer_pool_pin_lru_manager_core.sv
// Top level of the buffer pool pin/LRU manager.
//
// Usage: drive req_data and raise start; the transaction is taken at a clock
// edge where start is high and busy is low. Results appear on rsp_data, each
// for one cycle with rsp_valid high; rsp_data.last marks the final one, and
// busy falls in that same cycle. The receiver cannot stall: every strobed
// result is taken. One transaction is in work at a time.
//
// Order of work: a hit fetch shifts the recency list entries in front of the
// frame and puts it at the front. A miss takes a free frame if one is left,
// else evicts the least recent unpinned frame; the scan from the least recent
// end and the shift of the victim to the front cover the list between them.
// A fetch or new with no victim fails. Flush all sweeps the 16 frames one a
// cycle, writebacks going out during the sweep, then done.
//
// Reset clears the frame table, pin counts, dirty marks and list length;
// all frames count as free.
module buffer_pool_pin_lru_manager_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  bplru_pkg::req_type_type req_data,
   output logic                    rsp_valid,
   output bplru_pkg::rsp_type      rsp_data
);

   bplru_pkg::cmd_type cmd;
   bplru_pkg::sts_type sts;

   bplru_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   bplru_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the buffer pool pin/LRU manager core.
`timescale 1ns / 100ps

module testbench;

   localparam int PinMax = (1 << bplru_pkg::PinBits) - 1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   bplru_pkg::req_type_type req_data = '0;
   logic                    rsp_valid;
   bplru_pkg::rsp_type      rsp_data;

   buffer_pool_pin_lru_manager_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // shadow of the pool state
   logic [31:0]        pool_tag   [bplru_pkg::Frames];
   logic               pool_valid [bplru_pkg::Frames];
   int unsigned        pool_pins  [bplru_pkg::Frames];
   logic               pool_dirty [bplru_pkg::Frames];
   int unsigned        lru_list   [$];   // most recent first
   int unsigned        free_left;

   bplru_pkg::rsp_type pending_rsp [$];
   int unsigned        error_count = 0;
   logic [31:0]        recent_pages [$];

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic bplru_pkg::rsp_type make_rsp(logic [2:0] k, int unsigned f,
                                                   logic [31:0] p, int unsigned h,
                                                   int unsigned l);
      bplru_pkg::rsp_type r;
      r.kind = k; r.frame = f[3:0]; r.page = p; r.was_hit = h[0]; r.last = l[0];
      return r;
   endfunction

   // append one expected result
   function automatic void queue_rsp(bplru_pkg::rsp_type r);
      pending_rsp = {pending_rsp, r};
   endfunction

   function automatic void pool_reset();
      for (int i = 0; i < bplru_pkg::Frames; i++) begin
         pool_tag[i] = '0; pool_valid[i] = 1'b0; pool_pins[i] = 0; pool_dirty[i] = 1'b0;
      end
      lru_list.delete();
      free_left = bplru_pkg::Frames;
   endfunction

   function automatic int find_frame(logic [31:0] p);
      for (int i = 0; i < bplru_pkg::Frames; i++)
         if (pool_valid[i] && pool_tag[i] == p) return i;
      return -1;
   endfunction

   function automatic void lru_drop(int unsigned f);
      foreach (lru_list[i])
         if (lru_list[i] == f) begin
            lru_list.delete(i);
            return;
         end
   endfunction

   function automatic void lru_touch(int unsigned f);
      lru_drop(f);
      lru_list = {f, lru_list};
   endfunction

   // works out the results of one transaction and updates the shadow state
   function automatic void predict_pool(bplru_pkg::req_type_type rq);
      int f;
      f = -1;
      case (rq.req_type) inside
         bplru_pkg::REQ_FETCH, bplru_pkg::REQ_NEW: begin
            if (rq.req_type == bplru_pkg::REQ_FETCH) begin
               f = find_frame(rq.page_id);
               if (f >= 0) begin
                  if (pool_pins[f] < PinMax) pool_pins[f]++;
                  lru_touch(f);
                  queue_rsp(make_rsp(bplru_pkg::KIND_GRANTED, f, rq.page_id, 1, 1));
                  return;
               end
            end
            // victim: never-used frames first, else least recent unpinned
            if (free_left > 0) begin
               free_left--;
               f = free_left;
            end else begin
               for (int i = lru_list.size() - 1; i >= 0; i--)
                  if (pool_pins[lru_list[i]] == 0) begin
                     f = lru_list[i];
                     lru_list.delete(i);
                     if (pool_dirty[f])
                        queue_rsp(make_rsp(bplru_pkg::KIND_WRITEBACK, f, pool_tag[f], 0, 0));
                     pool_valid[f] = 1'b0;
                     pool_dirty[f] = 1'b0;
                     break;
                  end
            end
            if (f < 0) begin
               queue_rsp(make_rsp(bplru_pkg::KIND_FAILED, 0, rq.page_id, 0, 1));
               return;
            end
            if (rq.req_type == bplru_pkg::REQ_NEW) begin
               // duplicate mapping of the new tag is dropped
               for (int i = 0; i < bplru_pkg::Frames; i++)
                  if (i != f && pool_valid[i] && pool_tag[i] == rq.page_id) begin
                     pool_valid[i] = 1'b0;
                     pool_dirty[i] = 1'b0;
                  end
               queue_rsp(make_rsp(bplru_pkg::KIND_ZERO, f, rq.page_id, 0, 0));
               pool_dirty[f] = 1'b1;
            end else begin
               queue_rsp(make_rsp(bplru_pkg::KIND_LOAD, f, rq.page_id, 0, 0));
               pool_dirty[f] = 1'b0;
            end
            pool_tag[f] = rq.page_id;
            pool_valid[f] = 1'b1;
            pool_pins[f] = 1;
            lru_touch(f);
            queue_rsp(make_rsp(bplru_pkg::KIND_GRANTED, f, rq.page_id, 0, 1));
         end
         bplru_pkg::REQ_UNPIN: begin
            f = find_frame(rq.page_id);
            if (f < 0) begin
               queue_rsp(make_rsp(bplru_pkg::KIND_FAILED, 0, rq.page_id, 0, 1));
               return;
            end
            if (rq.dirty_flag) pool_dirty[f] = 1'b1;
            if (pool_pins[f] > 0) pool_pins[f]--;
            queue_rsp(make_rsp(bplru_pkg::KIND_DONE, f, rq.page_id, 0, 1));
         end
         bplru_pkg::REQ_FLUSH: begin
            f = find_frame(rq.page_id);
            if (f < 0) begin
               queue_rsp(make_rsp(bplru_pkg::KIND_FAILED, 0, rq.page_id, 0, 1));
               return;
            end
            queue_rsp(make_rsp(bplru_pkg::KIND_WRITEBACK, f, rq.page_id, 0, 0));
            pool_dirty[f] = 1'b0;
            queue_rsp(make_rsp(bplru_pkg::KIND_DONE, f, rq.page_id, 0, 1));
         end
         bplru_pkg::REQ_FLUSH_ALL: begin
            for (int i = 0; i < bplru_pkg::Frames; i++)
               if (pool_valid[i] && pool_dirty[i]) begin
                  queue_rsp(make_rsp(bplru_pkg::KIND_WRITEBACK, i, pool_tag[i], 0, 0));
                  pool_dirty[i] = 1'b0;
               end
            queue_rsp(make_rsp(bplru_pkg::KIND_DONE, 0, 0, 0, 1));
         end
         default:
            queue_rsp(make_rsp(bplru_pkg::KIND_FAILED, 0, rq.page_id, 0, 1));
      endcase
   endfunction

   // result checking at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", rsp_data));
         end else begin
            bplru_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.kind !== e.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_data.kind, e.kind));
            if (rsp_data.frame !== e.frame)
               report_mismatch($sformatf("frame %0d, want %0d", rsp_data.frame, e.frame));
            if (rsp_data.page !== e.page)
               report_mismatch($sformatf("page %h, want %h", rsp_data.page, e.page));
            if (rsp_data.was_hit !== e.was_hit)
               report_mismatch($sformatf("was_hit %b, want %b", rsp_data.was_hit, e.was_hit));
            if (rsp_data.last !== e.last)
               report_mismatch($sformatf("last %b, want %b", rsp_data.last, e.last));
         end
      end
   end

   // directed rows: request, page, dirty, typed expectation (kind, frame) where obvious
   typedef struct {
      logic [2:0]  rq;
      logic [31:0] pg;
      logic        dt;
      logic        known;
      logic [2:0]  want_kind;
      int unsigned want_frame;
   } stim_row_type;

   stim_row_type directed_rows [16] = '{
      '{bplru_pkg::REQ_UNPIN,     32'h0000_0005, 1'b1, 1'b1, bplru_pkg::KIND_FAILED, 0},
      '{bplru_pkg::REQ_FLUSH,     32'h0000_0005, 1'b0, 1'b1, bplru_pkg::KIND_FAILED, 0},
      '{bplru_pkg::REQ_FLUSH_ALL, 32'h1234_5678, 1'b0, 1'b1, bplru_pkg::KIND_DONE,   0},
      '{3'd5,                     32'hFFFF_FFFF, 1'b1, 1'b1, bplru_pkg::KIND_FAILED, 0},
      '{3'd7,                     32'h0000_0000, 1'b0, 1'b1, bplru_pkg::KIND_FAILED, 0},
      '{bplru_pkg::REQ_FETCH,     32'h0000_0000, 1'b0, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_FETCH,     32'hFFFF_FFFF, 1'b1, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_FETCH,     32'h0000_0000, 1'b0, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_NEW,       32'hA5A5_A5A5, 1'b0, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_NEW,       32'hA5A5_A5A5, 1'b0, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_UNPIN,     32'h0000_0000, 1'b1, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_UNPIN,     32'h0000_0000, 1'b0, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_UNPIN,     32'h0000_0000, 1'b0, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_FLUSH,     32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 0},
      '{bplru_pkg::REQ_FLUSH_ALL, 32'h0000_0000, 1'b0, 1'b0, 3'd0, 0},
      '{3'd6,                     32'h5A5A_5A5A, 1'b0, 1'b1, bplru_pkg::KIND_FAILED, 0}
   };

   int unsigned sent = 0;

   // drive one transaction at the falling edge and wait until it is taken
   task automatic send_request(bplru_pkg::req_type_type rq);
      @(negedge clock);
      while ($urandom_range(99) < 16 && (sent < 150 || sent > 300)) @(negedge clock);
      req_data <= rq;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pool(rq);
      sent++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   function automatic logic [31:0] pick_page();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70 && recent_pages.size() > 0)
         return recent_pages[$urandom_range(recent_pages.size() - 1)];
      if (sel < 80) return $urandom_range(3);
      if (sel < 85) return 32'hFFFF_FFFF - $urandom_range(3);
      return $urandom;
   endfunction

   initial begin
      bplru_pkg::req_type_type rq;
      int unsigned sel;
      logic [31:0] pg;
      pool_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         rq.req_type = directed_rows[i].rq;
         rq.page_id = directed_rows[i].pg;
         rq.dirty_flag = directed_rows[i].dt;
         if (directed_rows[i].known) begin
            // earlier results drain first so the typed row stands alone
            while (pending_rsp.size() != 0) @(posedge clock);
            send_request(rq);
            if (pending_rsp[$].kind != directed_rows[i].want_kind ||
                pending_rsp[$].frame != directed_rows[i].want_frame)
               report_mismatch($sformatf("row %0d typed expectation disagrees", i));
         end else begin
            send_request(rq);
         end
      end

      // fetch fresh pages until every frame is pinned; the final fetches find no victim
      for (int i = 0; i < bplru_pkg::Frames + 1; i++) begin
         rq.req_type = bplru_pkg::REQ_FETCH; rq.page_id = 32'h100 + i; rq.dirty_flag = 1'b0;
         send_request(rq);
      end

      // sender holds off until all results are in
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      // random part: mostly fetches and unpins over a small page set
      for (int n = 0; n < 430; n++) begin
         sel = $urandom_range(99);
         rq.page_id = pick_page();
         rq.dirty_flag = 1'($urandom_range(1));
         if (sel < 35)      rq.req_type = bplru_pkg::REQ_FETCH;
         else if (sel < 45) rq.req_type = bplru_pkg::REQ_NEW;
         else if (sel < 80) rq.req_type = bplru_pkg::REQ_UNPIN;
         else if (sel < 90) rq.req_type = bplru_pkg::REQ_FLUSH;
         else if (sel < 96) rq.req_type = bplru_pkg::REQ_FLUSH_ALL;
         else               rq.req_type = 3'($urandom_range(7, 5));
         if (recent_pages.size() < 24) begin
            pg = $urandom_range(40);
            recent_pages = {recent_pages, pg};
         end
         send_request(rq);
      end

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
